@@ design/cbsm_pkg.sv @@
`timescale 1ns / 1ps
package cbsm_pkg;

  localparam int unsigned IMAGE_BYTES = 65536;
  localparam int unsigned CFG_IDX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPERCHIP   = 2'd1;

  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_16K     = 3'd1,
    MODE_8K      = 3'd2,
    MODE_12K_RAM = 3'd3,
    MODE_1K      = 3'd4,
    MODE_TAPE    = 3'd5,
    MODE_2K_WSEL = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_IMAGE   = 2'd1,
    TGT_XRAM    = 2'd2,
    TGT_CONSOLE = 2'd3
  } target_e;

  localparam logic [5:0] TAPE_ROM_SLICE = 6'd6;
  localparam logic [2:0] CNT_MAX        = 3'd6;
  localparam logic [2:0] CNT_STORE      = 3'd5;

  typedef struct packed {
    logic [3:0][5:0] slice;
    logic [7:0]      hold;
    logic            wr_en;
    logic            pending;
    logic [2:0]      cnt;
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] address;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    target_e     target;
    logic [15:0] memory_address;
    logic        memory_write;
    logic [7:0]  write_value;
  } rsp_t;

  // 2K bank pair for each tape bank select code: {low pair, high pair}
  function automatic logic [3:0] tape_pair(input logic [2:0] sel);
    logic [3:0] p;
    case (sel)
      3'd0:    p = {2'd2, 2'd3};
      3'd1:    p = {2'd0, 2'd3};
      3'd2:    p = {2'd2, 2'd0};
      3'd3:    p = {2'd0, 2'd2};
      3'd4:    p = {2'd2, 2'd3};
      3'd5:    p = {2'd1, 2'd3};
      3'd6:    p = {2'd2, 2'd1};
      default: p = {2'd1, 2'd2};
    endcase
    return p;
  endfunction

  // slice * 1K + offset, folded into the image size (quotient is at most 7)
  function automatic logic [15:0] image_addr(input logic [3:0][5:0] slice,
                                             input logic [11:0] off);
    localparam logic [19:0] Img = 20'(IMAGE_BYTES);
    logic [19:0] r;
    r = {4'b0, slice[off[11:10]], off[9:0]};
    if (r >= (Img << 2)) r = r - (Img << 2);
    if (r >= (Img << 1)) r = r - (Img << 1);
    if (r >= Img)        r = r - Img;
    return r[15:0];
  endfunction

endpackage

@@ design/cbsm_if.sv @@
`timescale 1ns / 1ps
interface cbsm_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] address;
  logic [7:0]  write_byte;
  modport source (output valid, req_type, address, write_byte, input ready);
  modport sink   (input valid, req_type, address, write_byte, output ready);
endinterface

interface cbsm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  target;
  logic [15:0] memory_address;
  logic        memory_write;
  logic [7:0]  write_value;
  modport source (output valid, target, memory_address, memory_write, write_value,
                  input ready);
  modport sink   (input valid, target, memory_address, memory_write, write_value,
                  output ready);
endinterface

interface cbsm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

@@ design/cbsm_decode.sv @@
`timescale 1ns / 1ps
module cbsm_decode (
  input  cbsm_pkg::req_t   req_i,
  input  cbsm_pkg::state_t st_i,
  input  logic [2:0]       mode_i,
  input  logic             superchip_i,
  output cbsm_pkg::state_t st_o,
  output cbsm_pkg::rsp_t   rsp_o
);
  import cbsm_pkg::*;

  logic [11:0]     off;
  logic            wr;
  logic            top;
  logic [2:0]      cnt_inc;
  logic [15:0]     img_old;
  logic [3:0][5:0] hot;
  state_t          t;
  logic            t_store;
  logic [3:0]      pair;
  logic            xram;

  assign off     = req_i.address[11:0];
  assign wr      = req_i.req_type;
  assign top     = &req_i.address[15:12];
  assign cnt_inc = (st_i.cnt < CNT_MAX) ? st_i.cnt + 3'd1 : st_i.cnt;
  assign img_old = image_addr(st_i.slice, off);
  assign pair    = tape_pair(st_i.hold[4:2]);

  // hotspot switching for the 16K, 8K, 12K and 1K modes
  always_comb begin
    logic [1:0] bank;
    logic       sw;
    hot  = st_i.slice;
    bank = 2'd0;
    sw   = 1'b0;
    case (mode_i)
      MODE_16K: begin
        if (off inside {[12'hff6:12'hff9]}) begin
          sw   = 1'b1;
          bank = 2'(off - 12'hff6);
        end
      end
      MODE_8K: begin
        if (off inside {[12'hff8:12'hff9]}) begin
          sw   = 1'b1;
          bank = 2'(off - 12'hff8);
        end
      end
      MODE_12K_RAM: begin
        if (off inside {[12'hff8:12'hffa]}) begin
          sw   = 1'b1;
          bank = 2'(off - 12'hff8);
        end
      end
      MODE_1K: begin
        if (off inside {[12'hfe0:12'hff7]}) hot[off[4:3]] = {3'b0, off[2:0]};
      end
      default: ;
    endcase
    if (sw) begin
      for (int k = 0; k < 4; k++) hot[k] = {2'b00, bank, 2'(k)};
    end
  end

  // tape sequencer for a top page access
  always_comb begin
    t       = st_i;
    t.cnt   = cnt_inc;
    t_store = 1'b0;
    if (t.pending && cnt_inc == CNT_MAX) t.pending = 1'b0;
    if (off[11:8] == 4'h0 && (!t.wr_en || !t.pending)) begin
      t.hold    = off[7:0];
      t.cnt     = 3'd0;
      t.pending = 1'b1;
    end else if (off == 12'hff8) begin
      t.wr_en    = st_i.hold[1];
      t.slice[0] = {3'b0, pair[3:2], 1'b0};
      t.slice[1] = {3'b0, pair[3:2], 1'b1};
      t.slice[2] = {3'b0, pair[1:0], 1'b0};
      t.slice[3] = {3'b0, pair[1:0], 1'b1};
      t.pending  = 1'b0;
    end else if (!wr && t.wr_en && t.pending && cnt_inc == CNT_STORE) begin
      t.pending = 1'b0;
      t_store   = !off[11] || (st_i.slice[2] != TAPE_ROM_SLICE);
    end
  end

  always_comb begin
    st_o     = st_i;
    st_o.cnt = cnt_inc;
    rsp_o    = '0;
    xram     = ((mode_i == MODE_12K_RAM) && off[11:8] == 4'h0) ||
               (superchip_i && off[11:7] == 5'h00);
    if (req_i.address[12]) begin
      rsp_o.target         = TGT_IMAGE;
      rsp_o.memory_address = img_old;
      if (!wr) begin
        if (superchip_i && off[11:7] == 5'h01) begin
          rsp_o.target         = TGT_XRAM;
          rsp_o.memory_address = {9'b0, off[6:0]};
        end else if (mode_i == MODE_12K_RAM && off[11:8] == 4'h1) begin
          rsp_o.target         = TGT_XRAM;
          rsp_o.memory_address = {8'b0, off[7:0]};
        end else if (mode_i == MODE_TAPE) begin
          if (top) begin
            // tape reads see the mapping after the switch
            st_o                 = t;
            rsp_o.memory_address = image_addr(t.slice, off);
            if (t_store) begin
              rsp_o.memory_write = 1'b1;
              rsp_o.write_value  = t.hold;
            end
          end
        end else begin
          st_o.slice = hot;
        end
      end else begin
        if (xram) begin
          rsp_o.target         = TGT_XRAM;
          rsp_o.memory_address = {4'b0, off};
          rsp_o.memory_write   = 1'b1;
          rsp_o.write_value    = req_i.write_byte;
        end
        if (mode_i == MODE_TAPE) begin
          if (top) begin
            st_o = t;
          end else if (st_i.wr_en && st_i.pending && cnt_inc == CNT_STORE) begin
            st_o.pending = 1'b0;
            if ((!off[11] || st_i.slice[2] != TAPE_ROM_SLICE) && !xram) begin
              rsp_o.memory_write = 1'b1;
              rsp_o.write_value  = st_i.hold;
            end
          end
        end else begin
          st_o.slice = hot;
        end
      end
    end else if (!req_i.address[9] && req_i.address[7]) begin
      rsp_o.target         = TGT_CONSOLE;
      rsp_o.memory_address = {9'b0, req_i.address[6:0]};
      if (wr) begin
        rsp_o.memory_write = 1'b1;
        rsp_o.write_value  = req_i.write_byte;
      end
    end else if (wr && mode_i == MODE_2K_WSEL && req_i.address[7:6] == 2'b00) begin
      st_o.slice[0] = {req_i.write_byte[4:0], 1'b0};
      st_o.slice[1] = {req_i.write_byte[4:0], 1'b1};
    end
  end

endmodule

@@ design/cartridge_bank_switch_mapper.sv @@
`timescale 1ns / 1ps
// A result is registered as its request is accepted and is offered in the cycle after.
// Throughput: one request per cycle while results are read; the output register frees as it is read,
// so a new request is taken while a result is being delivered.
// Reset (async, active low): mode 0, extra RAM off, window k maps slice k,
// tape sequencer cleared, no result pending.
module cartridge_bank_switch_mapper (
  input  logic             clk_i,
  input  logic             rst_ni,
  cbsm_req_if.sink         req_i,
  cbsm_rsp_if.source       rsp_o,
  cbsm_cfg_if.sink         cfg_i
);
  import cbsm_pkg::*;

  logic [2:0] mode_q;
  logic       superchip_q;
  state_t     st_q, st_d;
  req_t       req;
  rsp_t       rsp_d, rsp_q;
  logic       rsp_valid_q;
  logic       req_fire;

  assign req.req_type   = req_i.req_type;
  assign req.address    = req_i.address;
  assign req.write_byte = req_i.write_byte;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  cbsm_decode u_decode (
    .req_i       (req),
    .st_i        (st_q),
    .mode_i      (mode_q),
    .superchip_i (superchip_q),
    .st_o        (st_d),
    .rsp_o       (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NONE;
      superchip_q <= 1'b0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_MAPPER_MODE) mode_q <= cfg_i.wdata[2:0];
      else if (cfg_i.index == CFG_SUPERCHIP) superchip_q <= cfg_i.wdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) st_q.slice[k] <= 6'(k);
      st_q.hold    <= '0;
      st_q.wr_en   <= 1'b0;
      st_q.pending <= 1'b0;
      st_q.cnt     <= '0;
    end else if (req_fire) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) rsp_q <= rsp_d;
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.target         = rsp_q.target;
  assign rsp_o.memory_address = rsp_q.memory_address;
  assign rsp_o.memory_write   = rsp_q.memory_write;
  assign rsp_o.write_value    = rsp_q.write_value;

endmodule

@@ design/cbsm_checker.sv @@
`timescale 1ns / 1ps
module cbsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        req_type_i,
  input logic [15:0] address_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  target_i,
  input logic [15:0] memory_address_i,
  input logic        memory_write_i,
  input logic [7:0]  write_value_i
);
  import cbsm_pkg::*;

  // every accepted request has a result on the next cycle
  a_req_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> rsp_valid_i)
    else $error("accepted request produced no result");

  // a stalled result blocks new requests
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |-> !req_ready_i)
    else $error("request taken while result stalled");

  // stalled result holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(target_i) &&
      $stable(memory_address_i) && $stable(memory_write_i) && $stable(write_value_i))
    else $error("stalled result changed");

  // console RAM read maps to console RAM without a store
  a_console_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && !req_type_i && !address_i[12] && !address_i[9] &&
      address_i[7]
    |=> target_i == TGT_CONSOLE && !memory_write_i &&
      memory_address_i == {9'b0, $past(address_i[6:0])})
    else $error("console RAM read mis-mapped");

endmodule

bind cartridge_bank_switch_mapper cbsm_checker u_cbsm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .req_type_i       (req_i.req_type),
  .address_i        (req_i.address),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .target_i         (rsp_o.target),
  .memory_address_i (rsp_o.memory_address),
  .memory_write_i   (rsp_o.memory_write),
  .write_value_i    (rsp_o.write_value)
);
